// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of i_clk outside reset
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vsm_pkg.sv =====
// shared types and constants of the voltage sweep tracker
package vsm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int STEP_W      = 6;
    localparam logic [STEP_W-1:0] LAST_STEP  = 6'd39;
    localparam logic [STEP_W-1:0] FIRST_STEP = 6'd1;

    localparam int VG_W    = 18;
    localparam int VO_W    = 10;
    localparam int CG_W    = 14;
    localparam int SCORE_W = 32;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_ARRAY_VOLT_GAIN     = 3'd0;
    localparam logic [2:0] REG_ARRAY_VOLT_OFFSET   = 3'd1;
    localparam logic [2:0] REG_ARRAY_CURR_GAIN     = 3'd2;
    localparam logic [2:0] REG_BATTERY_VOLT_GAIN   = 3'd3;
    localparam logic [2:0] REG_BATTERY_VOLT_OFFSET = 3'd4;
    localparam logic [2:0] REG_BATTERY_CURR_GAIN   = 3'd5;
    localparam logic [2:0] REG_POWER_THRESHOLD     = 3'd6;
    localparam logic [2:0] REG_OPTIMIZE_MODE       = 3'd7;

    localparam logic MODE_POWER      = 1'b0;
    localparam logic MODE_EFFICIENCY = 1'b1;

    typedef struct packed {
        logic [VG_W-1:0]    array_volt_gain;
        logic [VO_W-1:0]    array_volt_offset;
        logic [CG_W-1:0]    array_curr_gain;
        logic [VG_W-1:0]    battery_volt_gain;
        logic [VO_W-1:0]    battery_volt_offset;
        logic [CG_W-1:0]    battery_curr_gain;
        logic [SCORE_W-1:0] power_threshold;
        logic               optimize_mode;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] array_volt_raw;
        logic [SAMPLE_BITS-1:0] array_curr_raw;
        logic [SAMPLE_BITS-1:0] battery_volt_raw;
        logic [SAMPLE_BITS-1:0] battery_curr_raw;
    } t_raw;

    typedef struct packed {
        logic               done;
        logic               qualify;
        logic [SCORE_W-1:0] score;
    } t_core_res;

endpackage

// ===== rtl/vsm_regs.sv =====
// configuration register file on the apb port
module vsm_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vsm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [vsm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vsm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output vsm_pkg::t_cfg                     o_cfg
);

    vsm_pkg::t_cfg r_cfg;
    vsm_pkg::t_cfg n_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[vsm_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                vsm_pkg::REG_ARRAY_VOLT_GAIN:
                    n_cfg.array_volt_gain = pwdata[vsm_pkg::VG_W-1:0];
                vsm_pkg::REG_ARRAY_VOLT_OFFSET:
                    n_cfg.array_volt_offset = pwdata[vsm_pkg::VO_W-1:0];
                vsm_pkg::REG_ARRAY_CURR_GAIN:
                    n_cfg.array_curr_gain = pwdata[vsm_pkg::CG_W-1:0];
                vsm_pkg::REG_BATTERY_VOLT_GAIN:
                    n_cfg.battery_volt_gain = pwdata[vsm_pkg::VG_W-1:0];
                vsm_pkg::REG_BATTERY_VOLT_OFFSET:
                    n_cfg.battery_volt_offset = pwdata[vsm_pkg::VO_W-1:0];
                vsm_pkg::REG_BATTERY_CURR_GAIN:
                    n_cfg.battery_curr_gain = pwdata[vsm_pkg::CG_W-1:0];
                vsm_pkg::REG_POWER_THRESHOLD:
                    n_cfg.power_threshold = pwdata[vsm_pkg::SCORE_W-1:0];
                vsm_pkg::REG_OPTIMIZE_MODE:
                    n_cfg.optimize_mode = pwdata[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            vsm_pkg::REG_ARRAY_VOLT_GAIN:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.array_volt_gain);
            vsm_pkg::REG_ARRAY_VOLT_OFFSET:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.array_volt_offset);
            vsm_pkg::REG_ARRAY_CURR_GAIN:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.array_curr_gain);
            vsm_pkg::REG_BATTERY_VOLT_GAIN:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.battery_volt_gain);
            vsm_pkg::REG_BATTERY_VOLT_OFFSET:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.battery_volt_offset);
            vsm_pkg::REG_BATTERY_CURR_GAIN:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.battery_curr_gain);
            vsm_pkg::REG_POWER_THRESHOLD:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.power_threshold);
            vsm_pkg::REG_OPTIMIZE_MODE:
                prdata = vsm_pkg::CFG_DATA_W'(r_cfg.optimize_mode);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.array_volt_gain     <= 18'd114108;
            r_cfg.array_volt_offset   <= 10'd6;
            r_cfg.array_curr_gain     <= 14'd8115;
            r_cfg.battery_volt_gain   <= 18'd168970;
            r_cfg.battery_volt_offset <= 10'd67;
            r_cfg.battery_curr_gain   <= 14'd8247;
            r_cfg.power_threshold     <= 32'd1000000;
            r_cfg.optimize_mode       <= vsm_pkg::MODE_POWER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/vsm_core.sv =====
// scoring engine: shared multiplier and shift-subtract divider under a sequencer
module vsm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  vsm_pkg::t_raw      i_raw,
    input  vsm_pkg::t_cfg      i_cfg,
    output vsm_pkg::t_core_res o_res
);

    localparam int VMV_W  = vsm_pkg::VG_W + 1;
    localparam int IMA_W  = vsm_pkg::CG_W;
    localparam int PWR_W  = VMV_W + IMA_W;
    localparam int OPA_W  = VMV_W;
    localparam int OPB_W  = vsm_pkg::VG_W;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int Q_FRAC = 16;
    localparam int REM_W  = PWR_W + 1;
    localparam int SW     = vsm_pkg::SCORE_W;
    localparam int SB     = vsm_pkg::SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    localparam logic [2:0] OP_AV   = 3'd0;
    localparam logic [2:0] OP_AI   = 3'd1;
    localparam logic [2:0] OP_BV   = 3'd2;
    localparam logic [2:0] OP_BI   = 3'd3;
    localparam logic [2:0] OP_PIN  = 3'd4;
    localparam logic [2:0] OP_POUT = 3'd5;

    localparam logic [4:0] CNT_LAST_OP  = 5'(OP_POUT);
    localparam logic [4:0] CNT_LAST_DIV = 5'(SW - 1);

    logic [1:0]        r_state, n_state;
    logic [4:0]        r_cnt, n_cnt;
    logic [2:0]        r_wb_op, n_wb_op;
    logic              r_wb_vld, n_wb_vld;
    vsm_pkg::t_raw     r_raw, n_raw;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [VMV_W-1:0]  r_av, n_av, r_bv, n_bv;
    logic [IMA_W-1:0]  r_ai, n_ai, r_bi, n_bi;
    logic [PWR_W-1:0]  r_pin, n_pin, r_pout, n_pout;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [SW-1:0]     r_quo, n_quo;
    logic              r_done, n_done;
    logic              r_qual, n_qual;
    logic [SW-1:0]     r_score, n_score;

    logic [2:0]        issue_op;
    logic              issue;
    logic [OPA_W-1:0]  op_a;
    logic [OPB_W-1:0]  op_b;
    logic [REM_W-1:0]  trial;
    logic              trial_ge;
    logic              above_thr;
    logic              quo_ovf;

    assign o_res.done    = r_done;
    assign o_res.qualify = r_qual;
    assign o_res.score   = r_score;

    assign issue_op = r_cnt[2:0];
    assign issue    = (r_state == ST_MUL) && (r_cnt <= CNT_LAST_OP);

    always_comb begin
        case (issue_op)
            OP_AV: begin
                op_a = OPA_W'(r_raw.array_volt_raw);
                op_b = OPB_W'(i_cfg.array_volt_gain);
            end
            OP_AI: begin
                op_a = OPA_W'(r_raw.array_curr_raw);
                op_b = OPB_W'(i_cfg.array_curr_gain);
            end
            OP_BV: begin
                op_a = OPA_W'(r_raw.battery_volt_raw);
                op_b = OPB_W'(i_cfg.battery_volt_gain);
            end
            OP_BI: begin
                op_a = OPA_W'(r_raw.battery_curr_raw);
                op_b = OPB_W'(i_cfg.battery_curr_gain);
            end
            OP_PIN: begin
                op_a = r_av;
                op_b = OPB_W'(r_ai);
            end
            OP_POUT: begin
                op_a = r_bv;
                op_b = OPB_W'(r_bi);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign trial     = {r_rem[REM_W-2:0], r_quo[SW-1]};
    assign trial_ge  = trial >= REM_W'(r_pin);
    assign above_thr = r_pout > PWR_W'(i_cfg.power_threshold);
    assign quo_ovf   = {{Q_FRAC{1'b0}}, r_pout} >= {r_pin, {Q_FRAC{1'b0}}};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_wb_op  = issue_op;
        n_wb_vld = issue;
        n_raw    = r_raw;
        n_prod   = r_prod;
        n_av     = r_av;
        n_ai     = r_ai;
        n_bv     = r_bv;
        n_bi     = r_bi;
        n_pin    = r_pin;
        n_pout   = r_pout;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_done   = 1'b0;
        n_qual   = r_qual;
        n_score  = r_score;

        if (issue) begin
            n_prod = op_a * op_b;
        end

        if (r_wb_vld) begin
            case (r_wb_op)
                OP_AV:   n_av = VMV_W'(r_prod[SB +: vsm_pkg::VG_W])
                              + VMV_W'(i_cfg.array_volt_offset);
                OP_AI:   n_ai = r_prod[SB +: IMA_W];
                OP_BV:   n_bv = VMV_W'(r_prod[SB +: vsm_pkg::VG_W])
                              + VMV_W'(i_cfg.battery_volt_offset);
                OP_BI:   n_bi = r_prod[SB +: IMA_W];
                OP_PIN:  n_pin = r_prod[PWR_W-1:0];
                OP_POUT: n_pout = r_prod[PWR_W-1:0];
                default: n_prod = r_prod;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_raw   = i_raw;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_cnt = r_cnt + 5'd1;
                if (r_wb_vld && (r_wb_op == OP_POUT)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_qual = above_thr;
                n_done = 1'b1;
                n_state = ST_IDLE;
                if (i_cfg.optimize_mode == vsm_pkg::MODE_POWER) begin
                    n_score = r_pout[PWR_W-1] ? '1 : r_pout[SW-1:0];
                end else if ((r_pin == '0) || quo_ovf) begin
                    n_score = '1;
                end else if (above_thr) begin
                    n_done  = 1'b0;
                    n_rem   = REM_W'(r_pout[PWR_W-1:Q_FRAC]);
                    n_quo   = {r_pout[Q_FRAC-1:0], {(SW-Q_FRAC){1'b0}}};
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = trial_ge ? (trial - REM_W'(r_pin)) : trial;
                n_quo = {r_quo[SW-2:0], trial_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST_DIV) begin
                    n_score = {r_quo[SW-2:0], trial_ge};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_wb_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_wb_vld <= n_wb_vld;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_op <= n_wb_op;
        r_raw   <= n_raw;
        r_prod  <= n_prod;
        r_av    <= n_av;
        r_ai    <= n_ai;
        r_bv    <= n_bv;
        r_bi    <= n_bi;
        r_pin   <= n_pin;
        r_pout  <= n_pout;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_qual  <= n_qual;
        r_score <= n_score;
    end

endmodule

// ===== rtl/voltage_sweep_mppt_unit.sv =====
// Voltage sweep maximum power point tracker, top level.
// A transaction flagged as start (s_tuser) opens a sweep and answers with duty step 1;
// each following transaction carries the four converter readings for the step in force
// and is answered with the next step, until step 39 closes the sweep (m_tlast) and the
// best scoring step is held from then on. Start and holding transactions skip the scoring
// engine. A sweep transaction runs through one shared multiplier for six products; in
// efficiency mode a qualifying step with nonzero input power and no saturated ratio also
// runs a one-bit-per-cycle divider for 32 quotient bits. The input is not ready while a
// transaction is being scored; a finished result waits in the output register while the
// next transaction is taken. Configuration is written over the apb port; the user must
// write it only while the block is idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module voltage_sweep_mppt_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // array_volt_raw, array_curr_raw, battery_volt_raw, battery_curr_raw
    input  logic [4*vsm_pkg::SAMPLE_BITS-1:0] s_tdata,
    // start_req
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // duty_step, zero padded to a byte
    output logic [7:0]                     m_tdata,
    // sweeping
    output logic                           m_tuser,
    // sweep_done
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vsm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [vsm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [vsm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int SB = vsm_pkg::SAMPLE_BITS;
    localparam int STW = vsm_pkg::STEP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    vsm_pkg::t_cfg      cfg;
    vsm_pkg::t_raw      raw;
    vsm_pkg::t_core_res core_res;

    logic [1:0]                 r_state, n_state;
    logic                       r_in_sweep, n_in_sweep;
    logic [STW-1:0]             r_cur_step, n_cur_step;
    logic [STW-1:0]             r_best_step, n_best_step;
    logic [vsm_pkg::SCORE_W-1:0] r_best_score, n_best_score;
    logic [STW-1:0]             r_res_duty, n_res_duty;
    logic                       r_res_sweeping, n_res_sweeping;
    logic                       r_res_done, n_res_done;
    logic                       r_m_valid, n_m_valid;
    logic [STW-1:0]             r_m_duty, n_m_duty;
    logic                       r_m_sweeping, n_m_sweeping;
    logic                       r_m_done, n_m_done;

    logic in_acc;
    logic core_start;
    logic out_free;

    assign raw.array_volt_raw   = s_tdata[0*SB +: SB];
    assign raw.array_curr_raw   = s_tdata[1*SB +: SB];
    assign raw.battery_volt_raw = s_tdata[2*SB +: SB];
    assign raw.battery_curr_raw = s_tdata[3*SB +: SB];

    assign s_tready   = (r_state == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign core_start = in_acc && !s_tuser && r_in_sweep;
    assign out_free   = !r_m_valid || m_tready;

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(8-STW){1'b0}}, r_m_duty};
    assign m_tuser  = r_m_sweeping;
    assign m_tlast  = r_m_done;

    vsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vsm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_raw   (raw),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_comb begin
        n_state        = r_state;
        n_in_sweep     = r_in_sweep;
        n_cur_step     = r_cur_step;
        n_best_step    = r_best_step;
        n_best_score   = r_best_score;
        n_res_duty     = r_res_duty;
        n_res_sweeping = r_res_sweeping;
        n_res_done     = r_res_done;
        n_m_valid      = r_m_valid && !m_tready;
        n_m_duty       = r_m_duty;
        n_m_sweeping   = r_m_sweeping;
        n_m_done       = r_m_done;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        n_in_sweep     = 1'b1;
                        n_cur_step     = vsm_pkg::FIRST_STEP;
                        n_best_step    = '0;
                        n_best_score   = '0;
                        n_res_duty     = vsm_pkg::FIRST_STEP;
                        n_res_sweeping = 1'b1;
                        n_res_done     = 1'b0;
                        n_state        = ST_PUSH;
                    end else if (r_in_sweep) begin
                        n_state = ST_RUN;
                    end else begin
                        n_res_duty     = r_best_step;
                        n_res_sweeping = 1'b0;
                        n_res_done     = 1'b0;
                        n_state        = ST_PUSH;
                    end
                end
            end
            ST_RUN: begin
                if (core_res.done) begin
                    if (core_res.qualify && (core_res.score > r_best_score)) begin
                        n_best_score = core_res.score;
                        n_best_step  = r_cur_step;
                    end
                    if (r_cur_step >= vsm_pkg::LAST_STEP) begin
                        n_in_sweep     = 1'b0;
                        n_res_duty     = n_best_step;
                        n_res_sweeping = 1'b0;
                        n_res_done     = 1'b1;
                    end else begin
                        n_cur_step     = r_cur_step + 1'b1;
                        n_res_duty     = r_cur_step + 1'b1;
                        n_res_sweeping = 1'b1;
                        n_res_done     = 1'b0;
                    end
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_m_valid    = 1'b1;
                    n_m_duty     = r_res_duty;
                    n_m_sweeping = r_res_sweeping;
                    n_m_done     = r_res_done;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_in_sweep   <= 1'b0;
            r_cur_step   <= '0;
            r_best_step  <= '0;
            r_best_score <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_in_sweep   <= n_in_sweep;
            r_cur_step   <= n_cur_step;
            r_best_step  <= n_best_step;
            r_best_score <= n_best_score;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_duty     <= n_res_duty;
        r_res_sweeping <= n_res_sweeping;
        r_res_done     <= n_res_done;
        r_m_duty       <= n_m_duty;
        r_m_sweeping   <= n_m_sweeping;
        r_m_done       <= n_m_done;
    end

    `ASSERT_AT_CLK(a_core_done_in_run, core_res.done |-> (r_state == ST_RUN), "core finished outside run state")
    `ASSERT_NEXT(a_sweep_item_runs, core_start, (r_state == ST_RUN), "sweep transaction did not start scoring")
    `ASSERT_AT_CLK(a_step_range, r_in_sweep |-> ((r_cur_step >= vsm_pkg::FIRST_STEP) && (r_cur_step <= vsm_pkg::LAST_STEP)), "step out of range during sweep")
    `ASSERT_AT_CLK(a_done_not_sweeping, (m_tvalid && m_tlast) |-> !m_tuser, "sweep done flagged while sweeping")

endmodule

// ===== bench/tb_voltage_sweep_mppt_unit.sv =====
// testbench of the voltage sweep tracker: directed and random sweeps checked against a predictor
module tb_voltage_sweep_mppt_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 240;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    localparam vsm_pkg::t_cfg CFG_RESET = '{
        array_volt_gain:     18'd114108,
        array_volt_offset:   10'd6,
        array_curr_gain:     14'd8115,
        battery_volt_gain:   18'd168970,
        battery_volt_offset: 10'd67,
        battery_curr_gain:   14'd8247,
        power_threshold:     32'd1000000,
        optimize_mode:       vsm_pkg::MODE_POWER
    };

    typedef enum {
        SET_DEFAULT,
        SET_FULL_SCALE,
        SET_ZERO_GAIN,
        SET_SATURATE,
        SET_RANDOM_POWER,
        SET_RANDOM_EFFICIENCY,
        SET_EFFICIENCY_OPEN
    } t_setting;

    typedef struct packed {
        logic [vsm_pkg::STEP_W-1:0] duty;
        logic                       sweeping;
        logic                       done;
    } t_duty_cmd;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [4*vsm_pkg::SAMPLE_BITS-1:0]   s_tdata;
    logic                                s_tuser;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [7:0]                          m_tdata;
    logic                                m_tuser;
    logic                                m_tlast;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [vsm_pkg::CFG_ADDR_W-1:0]      paddr;
    logic [vsm_pkg::CFG_DATA_W-1:0]      pwdata;
    logic [vsm_pkg::CFG_DATA_W-1:0]      prdata;
    logic                                pready;

    vsm_pkg::t_cfg                       sweep_cfg;
    logic                                sweep_active;
    logic [vsm_pkg::STEP_W-1:0]          sweep_step;
    logic [vsm_pkg::STEP_W-1:0]          best_step_q;
    logic [vsm_pkg::SCORE_W-1:0]         best_score_q;

    t_duty_cmd             pending_cmds[$];
    int                    error_count;
    int                    idle_cycles;
    int                    sender_idle_pct;
    int                    recv_stall_pct;

    voltage_sweep_mppt_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned to_milli(input longint unsigned raw,
                                                 input longint unsigned gain,
                                                 input longint unsigned offset);
        return ((raw * gain) >> vsm_pkg::SAMPLE_BITS) + offset;
    endfunction

    function automatic logic [vsm_pkg::SCORE_W-1:0] step_score(input longint unsigned p_out,
                                                               input longint unsigned p_in);
        longint unsigned ratio;
        if (sweep_cfg.optimize_mode == vsm_pkg::MODE_POWER) begin
            return (p_out > 64'hFFFF_FFFF) ? '1 : 32'(p_out);
        end
        if (p_in == 0) begin
            return '1;
        end
        ratio = (p_out << 16) / p_in;
        return (ratio > 64'hFFFF_FFFF) ? '1 : 32'(ratio);
    endfunction

    function automatic t_duty_cmd track_step(input logic start, input vsm_pkg::t_raw raw);
        longint unsigned av, ai, bv, bi, p_out, p_in;
        logic [vsm_pkg::SCORE_W-1:0] score;
        t_duty_cmd cmd;
        cmd.done = 1'b0;
        if (start) begin
            sweep_active = 1'b1;
            sweep_step   = vsm_pkg::FIRST_STEP;
            best_step_q  = '0;
            best_score_q = '0;
        end else if (sweep_active) begin
            av = to_milli(raw.array_volt_raw, sweep_cfg.array_volt_gain,
                          sweep_cfg.array_volt_offset);
            ai = to_milli(raw.array_curr_raw, sweep_cfg.array_curr_gain, 0);
            bv = to_milli(raw.battery_volt_raw, sweep_cfg.battery_volt_gain,
                          sweep_cfg.battery_volt_offset);
            bi = to_milli(raw.battery_curr_raw, sweep_cfg.battery_curr_gain, 0);
            p_out = bv * bi;
            p_in  = av * ai;
            if (p_out > sweep_cfg.power_threshold) begin
                score = step_score(p_out, p_in);
                if (score > best_score_q) begin
                    best_score_q = score;
                    best_step_q  = sweep_step;
                end
            end
            if (sweep_step >= vsm_pkg::LAST_STEP) begin
                sweep_active = 1'b0;
                cmd.done     = 1'b1;
            end else begin
                sweep_step = sweep_step + 1'b1;
            end
        end
        cmd.duty     = sweep_active ? sweep_step : best_step_q;
        cmd.sweeping = sweep_active;
        return cmd;
    endfunction

    function automatic logic [vsm_pkg::SAMPLE_BITS-1:0] rand_reading();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return vsm_pkg::SAMPLE_BITS'($urandom_range(15));
            3:       return vsm_pkg::SAMPLE_BITS'($urandom_range(4095, 4000));
            default: return vsm_pkg::SAMPLE_BITS'($urandom_range(4095));
        endcase
    endfunction

    function automatic vsm_pkg::t_raw rand_readings();
        vsm_pkg::t_raw raw;
        raw.array_volt_raw   = rand_reading();
        raw.array_curr_raw   = rand_reading();
        raw.battery_volt_raw = rand_reading();
        raw.battery_curr_raw = rand_reading();
        return raw;
    endfunction

    function automatic vsm_pkg::t_raw readings(input int av, input int ai,
                                               input int bv, input int bi);
        vsm_pkg::t_raw raw;
        raw.array_volt_raw   = vsm_pkg::SAMPLE_BITS'(av);
        raw.array_curr_raw   = vsm_pkg::SAMPLE_BITS'(ai);
        raw.battery_volt_raw = vsm_pkg::SAMPLE_BITS'(bv);
        raw.battery_curr_raw = vsm_pkg::SAMPLE_BITS'(bi);
        return raw;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic start, input vsm_pkg::t_raw raw);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = start;
        s_tdata  = {raw.battery_curr_raw, raw.battery_volt_raw,
                    raw.array_curr_raw, raw.array_volt_raw};
        do @(posedge i_clk); while (!s_tready);
        pending_cmds.push_back(track_step(start, raw));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx,
                             input logic [vsm_pkg::CFG_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            vsm_pkg::REG_ARRAY_VOLT_GAIN:
                sweep_cfg.array_volt_gain = value[vsm_pkg::VG_W-1:0];
            vsm_pkg::REG_ARRAY_VOLT_OFFSET:
                sweep_cfg.array_volt_offset = value[vsm_pkg::VO_W-1:0];
            vsm_pkg::REG_ARRAY_CURR_GAIN:
                sweep_cfg.array_curr_gain = value[vsm_pkg::CG_W-1:0];
            vsm_pkg::REG_BATTERY_VOLT_GAIN:
                sweep_cfg.battery_volt_gain = value[vsm_pkg::VG_W-1:0];
            vsm_pkg::REG_BATTERY_VOLT_OFFSET:
                sweep_cfg.battery_volt_offset = value[vsm_pkg::VO_W-1:0];
            vsm_pkg::REG_BATTERY_CURR_GAIN:
                sweep_cfg.battery_curr_gain = value[vsm_pkg::CG_W-1:0];
            vsm_pkg::REG_POWER_THRESHOLD:
                sweep_cfg.power_threshold = value[vsm_pkg::SCORE_W-1:0];
            vsm_pkg::REG_OPTIMIZE_MODE:
                sweep_cfg.optimize_mode = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setting(input t_setting kind);
        vsm_pkg::t_cfg c;
        drain_results();
        c = CFG_RESET;
        case (kind)
            SET_FULL_SCALE: begin
                c = '1;
                c.power_threshold = '0;
                c.optimize_mode   = vsm_pkg::MODE_POWER;
            end
            SET_ZERO_GAIN: begin
                c = '0;
                c.array_volt_offset   = '1;
                c.battery_volt_offset = '1;
                c.optimize_mode       = vsm_pkg::MODE_EFFICIENCY;
            end
            SET_SATURATE: begin
                c = '1;
                c.optimize_mode = vsm_pkg::MODE_POWER;
            end
            SET_RANDOM_POWER, SET_RANDOM_EFFICIENCY: begin
                c.array_volt_gain     = vsm_pkg::VG_W'($urandom);
                c.array_volt_offset   = vsm_pkg::VO_W'($urandom);
                c.array_curr_gain     = vsm_pkg::CG_W'($urandom);
                c.battery_volt_gain   = vsm_pkg::VG_W'($urandom);
                c.battery_volt_offset = vsm_pkg::VO_W'($urandom);
                c.battery_curr_gain   = vsm_pkg::CG_W'($urandom);
                c.power_threshold     = $urandom_range(50000000);
                c.optimize_mode = (kind == SET_RANDOM_POWER) ? vsm_pkg::MODE_POWER
                                                             : vsm_pkg::MODE_EFFICIENCY;
            end
            SET_EFFICIENCY_OPEN: begin
                c.power_threshold = '0;
                c.optimize_mode   = vsm_pkg::MODE_EFFICIENCY;
            end
            default: ;
        endcase
        write_reg(vsm_pkg::REG_ARRAY_VOLT_GAIN,
                  vsm_pkg::CFG_DATA_W'(c.array_volt_gain));
        write_reg(vsm_pkg::REG_ARRAY_VOLT_OFFSET,
                  vsm_pkg::CFG_DATA_W'(c.array_volt_offset));
        write_reg(vsm_pkg::REG_ARRAY_CURR_GAIN,
                  vsm_pkg::CFG_DATA_W'(c.array_curr_gain));
        write_reg(vsm_pkg::REG_BATTERY_VOLT_GAIN,
                  vsm_pkg::CFG_DATA_W'(c.battery_volt_gain));
        write_reg(vsm_pkg::REG_BATTERY_VOLT_OFFSET,
                  vsm_pkg::CFG_DATA_W'(c.battery_volt_offset));
        write_reg(vsm_pkg::REG_BATTERY_CURR_GAIN,
                  vsm_pkg::CFG_DATA_W'(c.battery_curr_gain));
        write_reg(vsm_pkg::REG_POWER_THRESHOLD, c.power_threshold);
        write_reg(vsm_pkg::REG_OPTIMIZE_MODE,
                  vsm_pkg::CFG_DATA_W'(c.optimize_mode));
    endtask

    // mostly complete sweeps with random readings, some plateaus, rare restarts
    task automatic run_random_sweeps(input int n_items);
        int            sent;
        int            pause_at;
        vsm_pkg::t_raw raw;
        sent     = 0;
        pause_at = $urandom_range(n_items - 1);
        while (sent < n_items) begin
            send_item(1'b1, rand_readings());
            sent++;
            raw = rand_readings();
            for (int s = vsm_pkg::FIRST_STEP;
                 s <= vsm_pkg::LAST_STEP && sent < n_items; s++) begin
                if ($urandom_range(199) == 0) begin
                    break;
                end
                if ($urandom_range(3) != 0) begin
                    raw = rand_readings();
                end
                send_item(1'b0, raw);
                sent++;
                if (sent == pause_at) begin
                    drain_results();
                end
            end
            repeat ($urandom_range(2)) begin
                send_item(1'b0, rand_readings());
                sent++;
            end
        end
    endtask

    task automatic test_hold_before_sweep();
        send_item(1'b0, readings(0, 0, 0, 0));
        send_item(1'b0, readings(4095, 4095, 4095, 4095));
    endtask

    task automatic test_power_sweep_edges();
        send_item(1'b1, readings(4095, 4095, 4095, 4095));
        send_item(1'b0, readings(0, 0, 0, 0));
        send_item(1'b0, readings(4095, 4095, 4095, 4095));
        // same output power again, earlier step must stay best
        send_item(1'b0, readings(0, 0, 4095, 4095));
        send_item(1'b0, readings(4095, 4095, 10, 10));
        send_item(1'b0, readings(2048, 2048, 4095, 2048));
        // restart in the middle of a sweep
        send_item(1'b1, readings(0, 0, 0, 0));
        send_item(1'b0, readings(1, 1, 2048, 1024));
        send_item(1'b0, readings(4095, 0, 3000, 3000));
    endtask

    task automatic test_efficiency_edges();
        drain_results();
        write_reg(vsm_pkg::REG_OPTIMIZE_MODE,
                  vsm_pkg::CFG_DATA_W'(vsm_pkg::MODE_EFFICIENCY));
        send_item(1'b1, readings(0, 0, 0, 0));
        // zero input power
        send_item(1'b0, readings(4095, 0, 4095, 4095));
        // tiny input power, saturated ratio
        send_item(1'b0, readings(0, 1, 4095, 4095));
        send_item(1'b1, readings(4095, 4095, 4095, 4095));
        send_item(1'b0, readings(4095, 4095, 4095, 4095));
        send_item(1'b0, readings(1000, 2000, 3000, 2500));
        send_item(1'b0, readings(4095, 4095, 2000, 100));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input t_setting first_setting,
                                     input t_setting second_setting);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        apply_setting(first_setting);
        run_random_sweeps(RANDOM_ITEMS);
        apply_setting(second_setting);
        run_random_sweeps(RANDOM_ITEMS);
    endtask

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_duty_cmd want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = pending_cmds.pop_front();
                if (m_tdata !== {2'b00, want.duty}) begin
                    report_mismatch($sformatf("duty_step got %0d want %0d",
                                              m_tdata, want.duty));
                end
                if (m_tuser !== want.sweeping) begin
                    report_mismatch($sformatf("sweeping got %b want %b",
                                              m_tuser, want.sweeping));
                end
                if (m_tlast !== want.done) begin
                    report_mismatch($sformatf("sweep_done got %b want %b",
                                              m_tlast, want.done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        m_tready        = 1'b1;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        error_count     = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        sweep_cfg       = CFG_RESET;
        sweep_active    = 1'b0;
        sweep_step      = '0;
        best_step_q     = '0;
        best_score_q    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_hold_before_sweep();
        test_power_sweep_edges();
        test_efficiency_edges();
        test_random_phase(0, 0, SET_DEFAULT, SET_FULL_SCALE);
        test_random_phase(66, 0, SET_ZERO_GAIN, SET_SATURATE);
        test_random_phase(0, 66, SET_RANDOM_EFFICIENCY, SET_RANDOM_POWER);
        test_random_phase(10, 10, SET_EFFICIENCY_OPEN, SET_RANDOM_EFFICIENCY);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vsm_pkg.sv
rtl/vsm_regs.sv
rtl/vsm_core.sv
rtl/voltage_sweep_mppt_unit.sv
bench/tb_voltage_sweep_mppt_unit.sv
